@@ sv/ffxd_pkg.sv @@
// Package: word types and frame constants for the fixed-frame XOR deframer.
`default_nettype none
package ffxd_pkg;

  localparam logic [7:0]  END_MARK   = 8'h34;
  localparam logic [7:0]  START_MARK = 8'h32;
  localparam logic [3:0]  LAST_SUMMED = 4'd11;
  localparam logic [3:0]  CHECK_POS   = 4'd12;
  localparam logic [3:0]  END_POS     = 4'd13;
  localparam logic [3:0]  LAST_HEADER = 4'd3;
  localparam logic [15:0] IDLE_RESET  = 16'd500;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_BAD_END   = 2'd3
  } status_t;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  source;
    logic [7:0]  destination;
    logic [7:0]  command;
    logic [63:0] payload;
  } frame_word_t;

endpackage
`default_nettype wire

@@ sv/fixed_frame_xor_deframer.sv @@
// Top level: fixed 14-byte frame receiver with XOR checksum and idle timeout.
//
//  channel | handshake                 | word
//  --------+---------------------------+---------------------------------------
//  item    | item_valid / item_stall   | mode, rx_byte (byte or 1 ms tick)
//  frame   | frame_valid / frame_stall | status, source, destination, command,
//          |                           | payload (one per completed frame)
//  cfg     | cfg_wr_en                 | cfg_wr_data -> idle_limit
//
// One word per cycle while item_stall is low.
// Stages: input register, then frame tracker into the result register.
// Synchronous reset clears sync, count, XOR, idle count and both valids;
// idle_limit resets to 500.
// item_stall rises only while the result register holds a word under frame_stall.
`default_nettype none
module fixed_frame_xor_deframer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire ffxd_pkg::item_word_t  item,
  output logic                       frame_valid,
  input  wire logic                  frame_stall,
  output ffxd_pkg::frame_word_t      frame,
  input  wire logic                  cfg_wr_en,
  input  wire logic [15:0]           cfg_wr_data
);
  import ffxd_pkg::*;

  logic        item_q_valid;
  item_word_t  item_q;
  logic [15:0] idle_limit;
  logic        advance;
  logic        step;
  logic        done;
  frame_word_t result;

  assign advance    = !frame_valid || !frame_stall;
  assign step       = item_q_valid && advance;
  assign item_stall = item_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_RESET;
    end else if (cfg_wr_en) begin
      idle_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      item_q <= item;
    end
  end

  ffxd_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .word       (item_q),
    .idle_limit (idle_limit),
    .done       (done),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (advance) begin
      frame_valid <= step && done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && done) begin
      frame <= result;
    end
  end

endmodule
`default_nettype wire

@@ sv/ffxd_frame.sv @@
// Frame tracker: sync, byte count, running XOR, field capture and status checks.
`default_nettype none
module ffxd_frame (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire ffxd_pkg::item_word_t word,
  input  wire logic [15:0]        idle_limit,
  output logic                    done,
  output ffxd_pkg::frame_word_t   result
);
  import ffxd_pkg::*;

  logic        synced, synced_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [7:0]  start_seen, start_seen_next;
  logic [23:0] header_bytes, header_bytes_next;
  logic [63:0] payload_shift, payload_shift_next;
  logic [7:0]  checksum_seen, checksum_seen_next;
  status_t     status;

  always_comb begin
    synced_next        = synced;
    byte_count_next    = byte_count;
    running_xor_next   = running_xor;
    idle_ticks_next    = idle_ticks;
    start_seen_next    = start_seen;
    header_bytes_next  = header_bytes;
    payload_shift_next = payload_shift;
    checksum_seen_next = checksum_seen;
    done               = 1'b0;

    if (start_seen != START_MARK) begin
      status = ST_BAD_START;
    end else if (running_xor != checksum_seen) begin
      status = ST_BAD_SUM;
    end else if (word.rx_byte != END_MARK) begin
      status = ST_BAD_END;
    end else begin
      status = ST_OK;
    end

    if (step) begin
      if (word.mode == MODE_TICK) begin
        if (idle_ticks != 16'hFFFF) begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
        if (synced && (idle_ticks_next >= idle_limit)) begin
          synced_next      = 1'b0;
          byte_count_next  = '0;
          running_xor_next = '0;
        end
      end else begin
        idle_ticks_next = '0;
        if (!synced) begin
          if (word.rx_byte == END_MARK) begin
            synced_next      = 1'b1;
            byte_count_next  = '0;
            running_xor_next = '0;
          end
        end else begin
          byte_count_next = byte_count + 4'd1;
          if (byte_count == 4'd0) begin
            start_seen_next  = word.rx_byte;
            running_xor_next = '0;
          end else if (byte_count <= LAST_SUMMED) begin
            running_xor_next = running_xor ^ word.rx_byte;
            if (byte_count <= LAST_HEADER) begin
              header_bytes_next = {header_bytes[15:0], word.rx_byte};
            end else begin
              payload_shift_next = {payload_shift[55:0], word.rx_byte};
            end
          end else if (byte_count == CHECK_POS) begin
            checksum_seen_next = word.rx_byte;
          end else begin
            // end byte: frame complete
            done             = 1'b1;
            byte_count_next  = '0;
            running_xor_next = '0;
            if (word.rx_byte != END_MARK) begin
              synced_next = 1'b0;
            end
          end
        end
      end
    end
  end

  assign result.status      = status;
  assign result.source      = header_bytes[23:16];
  assign result.destination = header_bytes[15:8];
  assign result.command     = header_bytes[7:0];
  assign result.payload     = payload_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      synced      <= 1'b0;
      byte_count  <= '0;
      running_xor <= '0;
      idle_ticks  <= '0;
    end else begin
      synced      <= synced_next;
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
      idle_ticks  <= idle_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    start_seen    <= start_seen_next;
    header_bytes  <= header_bytes_next;
    payload_shift <= payload_shift_next;
    checksum_seen <= checksum_seen_next;
  end

endmodule
`default_nettype wire

@@ sv/ffxd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
`default_nettype none
module ffxd_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 item_stall,
  input wire logic                 frame_valid,
  input wire logic                 frame_stall,
  input wire ffxd_pkg::frame_word_t frame
);
  import ffxd_pkg::*;

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !frame_valid)
    else $error("result valid after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (frame_valid && frame_stall))
    else $error("input stalled while result side is free");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_stall) |=> (frame_valid && $stable(frame)))
    else $error("stalled result word changed");

  a_taken_frees_input: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !frame_stall) |-> !item_stall)
    else $error("input stalled while result is taken");

endmodule

bind fixed_frame_xor_deframer ffxd_checker u_ffxd_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .frame_valid (frame_valid),
  .frame_stall (frame_stall),
  .frame       (frame)
);
`default_nettype wire
